// ===== hdl/ltc_pkg.sv =====
// shared types and constants of the line export tab compressor
package ltc_pkg;

  localparam int CHAR_W       = 8;
  localparam int REP_W        = 13;
  localparam int TDATA_W      = 40;
  localparam int MAX_COLS_DEF = 4096;
  localparam int QUEUE_DEPTH  = 4;
  localparam int NUM_RUNS     = 4;

  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NL      = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] ESC_MASK   = 8'h1f;
  localparam logic [CHAR_W-1:0] ESC_RESET  = 8'd92;

  // run slots in emit order
  localparam int RUN_TAB   = 0;
  localparam int RUN_SPACE = 1;
  localparam int RUN_CHAR  = 2;
  localparam int RUN_NL    = 3;

  typedef struct packed {
    logic [NUM_RUNS-1:0] run_en;
    logic [REP_W-1:0]    tab_rep;
    logic [REP_W-1:0]    sp_rep;
    logic [CHAR_W-1:0]   ch;
    logic [REP_W-1:0]    line_len;
    logic                ovf;
  } cmd_t;

endpackage

// ===== hdl/ltc_front.sv =====
// front end: escape decoding, column tracking and run planning per character
module ltc_front
  import ltc_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              line_end,
  input  logic              cfg_we,
  input  logic [CHAR_W-1:0] cfg_data,
  output logic              push,
  output cmd_t              cmd
);

  localparam int COL_W = $clog2(MAX_COLS) + 1;
  localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(MAX_COLS);
  localparam logic [COL_W-1:0] TAB_MASK  = {{(COL_W-3){1'b1}}, 3'b000};

  logic [CHAR_W-1:0] esc_code;
  logic [COL_W-1:0]  pos, pos_next;
  logic [COL_W-1:0]  noc, noc_next;
  logic [COL_W-1:0]  emitted, emitted_next;
  logic              esc_pend, esc_pend_next;
  logic              skip, skip_next;
  logic              col_ovf, col_ovf_next;

  logic              take;
  logic              do_nl;
  logic [CHAR_W-1:0] tc;
  logic [COL_W-1:0]  tabs;
  logic [COL_W-1:0]  base;
  logic [COL_W-1:0]  spaces;
  logic              acc;

  assign acc = in_valid && in_ready;

  always_comb begin
    pos_next      = pos;
    noc_next      = noc;
    emitted_next  = emitted;
    esc_pend_next = esc_pend;
    skip_next     = skip;
    col_ovf_next  = col_ovf;
    take          = 1'b0;
    do_nl         = 1'b0;
    tc            = in_char;
    tabs          = '0;
    base          = noc;
    spaces        = '0;
    cmd           = '0;

    // decode the item
    if (line_end) begin
      if (skip) begin
        skip_next = 1'b0;
      end else begin
        take  = esc_pend;
        tc    = esc_code;
        do_nl = 1'b1;
      end
    end else if (!skip) begin
      if (esc_pend) begin
        esc_pend_next = 1'b0;
        if (in_char == CH_NL) begin
          take      = 1'b1;
          tc        = esc_code;
          do_nl     = 1'b1;
          skip_next = 1'b1;
        end else begin
          take = 1'b1;
          tc   = (in_char == esc_code) ? in_char : (in_char & ESC_MASK);
        end
      end else if (in_char == CH_NL) begin
        do_nl     = 1'b1;
        skip_next = 1'b1;
      end else if (in_char == esc_code) begin
        esc_pend_next = 1'b1;
      end else begin
        take = 1'b1;
      end
    end

    // place the character
    if (take) begin
      if (pos >= COL_LIMIT) begin
        col_ovf_next = 1'b1;
      end else begin
        pos_next = pos + COL_W'(1);
        if (tc != CH_SPACE) begin
          if (noc == '0) begin
            tabs = pos >> 3;
            base = pos & TAB_MASK;
          end
          spaces = pos - base;
          cmd.run_en[RUN_TAB]   = (tabs != '0);
          cmd.tab_rep           = REP_W'(tabs);
          cmd.run_en[RUN_SPACE] = (spaces != '0);
          cmd.sp_rep            = REP_W'(spaces);
          cmd.run_en[RUN_CHAR]  = 1'b1;
          cmd.ch                = tc;
          noc_next              = pos + COL_W'(1);
          emitted_next          = emitted + tabs + spaces + COL_W'(1);
        end
      end
    end

    // close the line
    if (line_end || do_nl) begin
      if (do_nl) begin
        cmd.run_en[RUN_NL] = 1'b1;
        cmd.line_len       = REP_W'(emitted_next + COL_W'(1));
        cmd.ovf            = col_ovf_next;
      end
      pos_next      = '0;
      noc_next      = '0;
      emitted_next  = '0;
      esc_pend_next = 1'b0;
      col_ovf_next  = 1'b0;
    end
  end

  assign push = acc && (cmd.run_en != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_code <= ESC_RESET;
      pos      <= '0;
      noc      <= '0;
      emitted  <= '0;
      esc_pend <= 1'b0;
      skip     <= 1'b0;
      col_ovf  <= 1'b0;
    end else begin
      if (cfg_we) begin
        esc_code <= cfg_data;
      end
      if (acc) begin
        pos      <= pos_next;
        noc      <= noc_next;
        emitted  <= emitted_next;
        esc_pend <= esc_pend_next;
        skip     <= skip_next;
        col_ovf  <= col_ovf_next;
      end
    end
  end

endmodule

// ===== hdl/ltc_queue.sv =====
// short command queue between front and back end
module ltc_queue
  import ltc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full       = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== hdl/ltc_back.sv =====
// back end: expands one command into its runs, one output beat per cycle while the output is not stalled
module ltc_back
  import ltc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  cmd_t               head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_char,
  output logic [REP_W-1:0]   repeat_res,
  output logic [REP_W-1:0]   line_length,
  output logic               overflow,
  output logic               last
);

  logic [NUM_RUNS-1:0] sent;
  logic [NUM_RUNS-1:0] remain;
  logic [NUM_RUNS-1:0] sel;
  logic                sel_last;
  logic                emit;
  logic [CHAR_W-1:0]   ch_sel;
  logic [REP_W-1:0]    rep_sel;

  assign remain   = head.run_en & ~sent;
  assign sel      = remain & (~remain + NUM_RUNS'(1));
  assign sel_last = ((remain & ~sel) == '0);
  assign emit     = head_valid && (!out_valid || out_ready);
  assign pop      = emit && sel_last;

  always_comb begin
    ch_sel  = head.ch;
    rep_sel = REP_W'(1);
    if (sel[RUN_TAB]) begin
      ch_sel  = CH_TAB;
      rep_sel = head.tab_rep;
    end else if (sel[RUN_SPACE]) begin
      ch_sel  = CH_SPACE;
      rep_sel = head.sp_rep;
    end else if (sel[RUN_NL]) begin
      ch_sel  = CH_NL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        sent      <= sel_last ? '0 : (sent | sel);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char    <= ch_sel;
      repeat_res  <= rep_sel;
      line_length <= sel[RUN_NL] ? head.line_len : '0;
      overflow    <= sel[RUN_NL] ? head.ovf : 1'b0;
      last        <= sel_last;
    end
  end

endmodule

// ===== hdl/line_export_tab_compressor.sv =====
// top level of the line export tab compressor
// an accepted item that makes a command writes it into the command queue at once; its runs
// then leave through the output register, one run per cycle while m_tready holds (one to four runs)
// input side takes one beat per cycle while the four-entry command queue has room;
// sustained rate is bounded by the back end emitting one run per cycle
// reset clears the line state, the queue and the output, and sets the escape code to 92
module line_export_tab_compressor
  import ltc_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // in_char
  input  logic               s_tlast,   // line_end
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // out_char, repeat_res, line_length, zero pad
  output logic               m_tuser,   // overflow
  output logic               m_tlast,   // last
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  logic              push;
  cmd_t              push_cmd;
  logic              full;
  logic              head_valid;
  cmd_t              head;
  logic              pop;
  logic [CHAR_W-1:0] out_char;
  logic [REP_W-1:0]  repeat_res;
  logic [REP_W-1:0]  line_length;

  assign cfg_ready = 1'b1;
  assign s_tready  = !full;
  assign m_tdata   = {(TDATA_W - CHAR_W - 2*REP_W)'(0), line_length, repeat_res, out_char};

  ltc_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_char  (s_tdata),
    .line_end (s_tlast),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .push     (push),
    .cmd      (push_cmd)
  );

  ltc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  ltc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_char    (out_char),
    .repeat_res  (repeat_res),
    .line_length (line_length),
    .overflow    (m_tuser),
    .last        (m_tlast)
  );

endmodule

// ===== hdl/ltc_checker.sv =====
// port-level checks for the line export tab compressor
module ltc_checker
  import ltc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tuser,
  input logic               m_tlast
);

  // a stalled output beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // nothing comes out right after reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // a line length only travels on a newline that closes its item
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:21] != '0) |-> (m_tdata[7:0] == CH_NL) && m_tlast)
    else $error("line length on a beat that is not a final newline");

  // overflow only travels with a newline
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[7:0] == CH_NL) && m_tlast)
    else $error("overflow on a beat that is not a final newline");

endmodule

bind line_export_tab_compressor ltc_checker u_ltc_checker (.*);
